[sv/tme_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// tme_pkg: shared types and constants of the tape machine execute unit
// Tape geometry, operation codes and the command and status bundles that
// pass between the controller and the datapath.
// ============================================================================
package tme_pkg;

    // tape geometry
    localparam int TAPE_CELLS = 32768;
    localparam int ADDR_W     = $clog2(TAPE_CELLS);

    // fixed field widths
    localparam int OP_W   = 4;
    localparam int AMT_W  = 15;
    localparam int OFFS_W = 16;
    localparam int HEAD_W = 15;

    // working widths for head moves and target sums
    localparam int MOVE_W = ((ADDR_W > AMT_W) ? ADDR_W : AMT_W) + 1;
    localparam int TSUM_W = ((ADDR_W > OFFS_W) ? ADDR_W : OFFS_W) + 2;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [MOVE_W-1:0] move_t;
    typedef logic [TSUM_W-1:0] tsum_t;
    typedef logic [HEAD_W-1:0] head_pos_t;
    typedef logic [OP_W-1:0]   op_t;

    localparam addr_t HEAD_MAX = addr_t'(TAPE_CELLS - 1);
    localparam move_t MOVE_MAX = move_t'(TAPE_CELLS - 1);
    localparam tsum_t TSUM_MAX = tsum_t'(TAPE_CELLS - 1);

    // operation codes
    localparam op_t OP_ADD     = 4'd0;
    localparam op_t OP_SUB     = 4'd1;
    localparam op_t OP_RIGHT   = 4'd2;
    localparam op_t OP_LEFT    = 4'd3;
    localparam op_t OP_OUT     = 4'd4;
    localparam op_t OP_IN      = 4'd5;
    localparam op_t OP_TEST    = 4'd6;
    localparam op_t OP_CLOSE   = 4'd7;
    localparam op_t OP_CLEAR   = 4'd8;
    localparam op_t OP_SET     = 4'd9;
    localparam op_t OP_SCANR   = 4'd10;
    localparam op_t OP_SCANL   = 4'd11;
    localparam op_t OP_MOVEADD = 4'd12;
    localparam op_t OP_DIST    = 4'd13;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch an input beat, compute targets
        logic exec;       // first step on the current cell
        logic scan;       // one scan step
        logic look;       // sample the cell under a moved head
        logic wr_first;   // add into first target
        logic wr_second;  // add into second target
        logic wr_zero;    // clear the current cell
        logic clr_write;  // one step of the tape clearing pass
        logic emit;       // load the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic clr_last;
        logic scan_stop;
        logic out_busy;
    } sts_t;

endpackage

[sv/tme_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// tme_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module tme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/tme_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// tme_ctrl: sequencer of the tape machine execute unit
// Steps each operation through its tape accesses and hands the datapath
// one command bundle per cycle.
// ============================================================================
module tme_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  tme_pkg::sts_t sts,
    output tme_pkg::cmd_t cmd,
    output logic          in_stall
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_LOOK  = 4'd4;
    localparam logic [3:0] S_WR1   = 4'd5;
    localparam logic [3:0] S_WR2   = 4'd6;
    localparam logic [3:0] S_WRZ   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register; the clearing pass runs first after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                case (sts.op)
                    tme_pkg::OP_RIGHT,
                    tme_pkg::OP_LEFT:   state_next = S_LOOK;
                    tme_pkg::OP_SCANR,
                    tme_pkg::OP_SCANL:  state_next = sts.scan_stop ? S_DONE : S_SCAN;
                    tme_pkg::OP_MOVEADD,
                    tme_pkg::OP_DIST:   state_next = S_WR1;
                    default:            state_next = S_DONE;
                endcase
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_stop)
                begin
                    state_next = S_DONE;
                end
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_DONE;
            end
            S_WR1:
            begin
                cmd.wr_first = 1'b1;
                state_next   = (sts.op == tme_pkg::OP_DIST) ? S_WR2 : S_WRZ;
            end
            S_WR2:
            begin
                cmd.wr_second = 1'b1;
                state_next    = S_WRZ;
            end
            S_WRZ:
            begin
                cmd.wr_zero = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/tme_dp.sv]
`timescale 1ns / 1ps
// ============================================================================
// tme_dp: datapath of the tape machine execute unit
// Tape memory, head pointer, operand registers, cell arithmetic and the
// output register of the result channel.
// ============================================================================
module tme_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tme_pkg::cmd_t              cmd,
    output tme_pkg::sts_t              sts,
    // input beat
    input  logic [3:0]                 opcode,
    input  logic [14:0]                amount,
    input  logic signed [15:0]         offset_first,
    input  logic [7:0]                 factor_first,
    input  logic signed [15:0]         offset_second,
    input  logic [7:0]                 factor_second,
    input  logic [7:0]                 in_byte,
    // result beat
    input  logic                       res_stall,
    output logic                       res_valid,
    output logic                       out_valid,
    output logic [7:0]                 out_char,
    output logic                       cell_nonzero,
    output logic [14:0]                head_position,
    output logic                       status
);

    // clamp head plus signed offset to the tape ends
    function automatic tme_pkg::addr_t clamp_target(tme_pkg::addr_t h, logic [15:0] off);
        tme_pkg::tsum_t s;
        tme_pkg::addr_t r;
        s = tme_pkg::tsum_t'(h)
          + {{(tme_pkg::TSUM_W - tme_pkg::OFFS_W){off[tme_pkg::OFFS_W-1]}}, off};
        if (s[tme_pkg::TSUM_W-1])
        begin
            r = '0;
        end
        else if (s > tme_pkg::TSUM_MAX)
        begin
            r = tme_pkg::HEAD_MAX;
        end
        else
        begin
            r = tme_pkg::addr_t'(s);
        end
        return r;
    endfunction

    // state and operand registers
    tme_pkg::addr_t head_reg, head_next;
    tme_pkg::addr_t clr_addr_reg, clr_addr_next;
    tme_pkg::op_t   op_reg, op_next;
    logic [14:0]    amount_reg, amount_next;
    tme_pkg::addr_t tgt1_reg, tgt1_next;
    tme_pkg::addr_t tgt2_reg, tgt2_next;
    logic [7:0]     f1_reg, f1_next;
    logic [7:0]     f2_reg, f2_next;
    logic [7:0]     in_byte_reg, in_byte_next;
    logic [7:0]     prod1_reg, prod1_next;
    logic [7:0]     prod2_reg, prod2_next;
    logic [7:0]     sum1_reg, sum1_next;

    // result staging
    logic           res_outv_reg, res_outv_next;
    logic [7:0]     res_char_reg, res_char_next;
    logic           res_nz_reg, res_nz_next;
    logic           res_status_reg, res_status_next;

    // output register
    logic                   obuf_valid_reg;
    logic                   o_outv_reg;
    logic [7:0]             o_char_reg;
    logic                   o_nz_reg;
    tme_pkg::head_pos_t     o_head_reg;
    logic                   o_status_reg;

    // tape port signals
    logic           ram_we;
    tme_pkg::addr_t ram_waddr;
    logic [7:0]     ram_wdata;
    tme_pkg::addr_t ram_raddr;
    logic [7:0]     ram_rdata;

    // helpers
    tme_pkg::move_t h_ext, a_ext, sum_r;
    tme_pkg::addr_t head_right, head_left, head_up, head_dn;
    logic [15:0]    mul1_full, mul2_full;
    logic [7:0]     rd_byte, newv, cell2;
    logic           scan_act, scan_fwd, at_end, scan_stop;

    tme_ram #(
        .WIDTH (8),
        .DEPTH (tme_pkg::TAPE_CELLS)
    ) u_tape (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // clamped head moves
    assign h_ext      = tme_pkg::move_t'(head_reg);
    assign a_ext      = tme_pkg::move_t'(amount_reg);
    assign sum_r      = h_ext + a_ext;
    assign head_right = (sum_r > tme_pkg::MOVE_MAX) ? tme_pkg::HEAD_MAX
                                                    : tme_pkg::addr_t'(sum_r);
    assign head_left  = (h_ext < a_ext) ? '0 : tme_pkg::addr_t'(h_ext - a_ext);
    assign head_up    = head_reg + 1'b1;
    assign head_dn    = head_reg - 1'b1;

    // scaled contributions, low byte only
    assign rd_byte   = ram_rdata;
    assign mul1_full = {8'h00, rd_byte} * {8'h00, f1_reg};
    assign mul2_full = {8'h00, rd_byte} * {8'h00, f2_reg};

    // scan step on the cell under the head; stop flag only read during scans
    assign scan_fwd  = (op_reg == tme_pkg::OP_SCANR);
    assign scan_act  = cmd.scan
                     || (cmd.exec && (scan_fwd || op_reg == tme_pkg::OP_SCANL));
    assign at_end    = scan_fwd ? (head_reg == tme_pkg::HEAD_MAX) : (head_reg == '0);
    assign scan_stop = (rd_byte == 8'h00) || at_end;

    // second target sees the first write when both hit the same cell
    assign cell2 = (tgt2_reg == tgt1_reg) ? sum1_reg : rd_byte;

    // new value for single-cell writes
    always_comb
    begin
        case (op_reg)
            tme_pkg::OP_ADD: newv = rd_byte + amount_reg[7:0];
            tme_pkg::OP_SUB: newv = rd_byte - amount_reg[7:0];
            tme_pkg::OP_IN:  newv = in_byte_reg;
            tme_pkg::OP_SET: newv = amount_reg[7:0];
            default:         newv = 8'h00;
        endcase
    end

    // operation sequencing
    always_comb
    begin
        head_next       = head_reg;
        clr_addr_next   = clr_addr_reg;
        op_next         = op_reg;
        amount_next     = amount_reg;
        tgt1_next       = tgt1_reg;
        tgt2_next       = tgt2_reg;
        f1_next         = f1_reg;
        f2_next         = f2_reg;
        in_byte_next    = in_byte_reg;
        prod1_next      = prod1_reg;
        prod2_next      = prod2_reg;
        sum1_next       = sum1_reg;
        res_outv_next   = res_outv_reg;
        res_char_next   = res_char_reg;
        res_nz_next     = res_nz_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_wdata       = 8'h00;
        ram_raddr       = head_reg;

        // tape clearing pass
        if (cmd.clr_write)
        begin
            ram_we        = 1'b1;
            ram_waddr     = clr_addr_reg;
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        // capture beat
        if (cmd.load)
        begin
            op_next         = opcode;
            amount_next     = amount;
            tgt1_next       = clamp_target(head_reg, offset_first);
            tgt2_next       = clamp_target(head_reg, offset_second);
            f1_next         = factor_first;
            f2_next         = factor_second;
            in_byte_next    = in_byte;
            res_outv_next   = 1'b0;
            res_char_next   = 8'h00;
            res_status_next = 1'b0;
        end

        // first step on the current cell
        if (cmd.exec)
        begin
            case (op_reg)
                tme_pkg::OP_ADD,
                tme_pkg::OP_SUB,
                tme_pkg::OP_IN,
                tme_pkg::OP_CLEAR,
                tme_pkg::OP_SET:
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = newv;
                    res_nz_next = (newv != 8'h00);
                end
                tme_pkg::OP_RIGHT:
                begin
                    head_next = head_right;
                    ram_raddr = head_right;
                end
                tme_pkg::OP_LEFT:
                begin
                    head_next = head_left;
                    ram_raddr = head_left;
                end
                tme_pkg::OP_OUT:
                begin
                    res_outv_next = 1'b1;
                    res_char_next = rd_byte;
                    res_nz_next   = (rd_byte != 8'h00);
                end
                tme_pkg::OP_MOVEADD,
                tme_pkg::OP_DIST:
                begin
                    ram_raddr   = tgt1_reg;
                    prod1_next  = mul1_full[7:0];
                    prod2_next  = mul2_full[7:0];
                    res_nz_next = 1'b0;
                end
                default:
                begin
                    res_nz_next = (rd_byte != 8'h00);
                end
            endcase
        end

        // scan: stop on zero or at the tape end, else step and read ahead
        if (scan_act)
        begin
            if (rd_byte == 8'h00)
            begin
                res_nz_next = 1'b0;
            end
            else if (at_end)
            begin
                res_nz_next     = 1'b1;
                res_status_next = 1'b1;
            end
            else
            begin
                head_next = scan_fwd ? head_up : head_dn;
                ram_raddr = scan_fwd ? head_up : head_dn;
            end
        end

        // cell under the moved head
        if (cmd.look)
        begin
            res_nz_next = (rd_byte != 8'h00);
        end

        // first target update, read second target
        if (cmd.wr_first)
        begin
            ram_we    = 1'b1;
            ram_waddr = tgt1_reg;
            ram_wdata = rd_byte + prod1_reg;
            sum1_next = rd_byte + prod1_reg;
            ram_raddr = tgt2_reg;
        end

        // second target update
        if (cmd.wr_second)
        begin
            ram_we    = 1'b1;
            ram_waddr = tgt2_reg;
            ram_wdata = cell2 + prod2_reg;
        end

        // current cell ends at zero
        if (cmd.wr_zero)
        begin
            ram_we = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            clr_addr_reg   <= '0;
            obuf_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            clr_addr_reg <= clr_addr_next;
            if (cmd.emit)
            begin
                obuf_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                obuf_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        amount_reg     <= amount_next;
        tgt1_reg       <= tgt1_next;
        tgt2_reg       <= tgt2_next;
        f1_reg         <= f1_next;
        f2_reg         <= f2_next;
        in_byte_reg    <= in_byte_next;
        prod1_reg      <= prod1_next;
        prod2_reg      <= prod2_next;
        sum1_reg       <= sum1_next;
        res_outv_reg   <= res_outv_next;
        res_char_reg   <= res_char_next;
        res_nz_reg     <= res_nz_next;
        res_status_reg <= res_status_next;
        if (cmd.emit)
        begin
            o_outv_reg   <= res_outv_reg;
            o_char_reg   <= res_char_reg;
            o_nz_reg     <= res_nz_reg;
            o_head_reg   <= tme_pkg::head_pos_t'(head_reg);
            o_status_reg <= res_status_reg;
        end
    end

    // status to the controller
    assign sts.op        = op_reg;
    assign sts.clr_last  = (clr_addr_reg == tme_pkg::HEAD_MAX);
    assign sts.scan_stop = scan_stop;
    assign sts.out_busy  = obuf_valid_reg && res_stall;

    assign res_valid     = obuf_valid_reg;
    assign out_valid     = o_outv_reg;
    assign out_char      = o_char_reg;
    assign cell_nonzero  = o_nz_reg;
    assign head_position = o_head_reg;
    assign status        = o_status_reg;

endmodule

[sv/tape_machine_execute_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tape_machine_execute_unit: byte tape machine, one operation per beat
// Executes add, sub, head moves, out, in, test, close, clear, set, scans,
// move-add and distribute against a 32768-cell byte tape.
// ============================================================================
// After reset the unit clears the tape, one cell per cycle, and holds
// in_stall high until the pass ends. Then it takes one operation at a time;
// all tape accesses go through one memory with one write and one registered
// read port. Cell operations, out, test and close pass exec and done; head
// moves pass exec, look and done; move-add passes exec, first write, zero
// write and done; distribute adds a second write (two read-modify-writes
// plus the clear of the current cell); a scan steps cell by cell until it
// stops. A stalled result beat waits in the output register while the next
// operation is accepted; a further result then waits for it to drain.
module tape_machine_execute_unit (
    input  logic               clk,
    input  logic               rst_n,
    // operation channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         opcode,
    input  logic [14:0]        amount,
    input  logic signed [15:0] offset_first,
    input  logic [7:0]         factor_first,
    input  logic signed [15:0] offset_second,
    input  logic [7:0]         factor_second,
    input  logic [7:0]         in_byte,
    // result channel
    output logic               res_valid,
    input  logic               res_stall,
    output logic               out_valid,
    output logic [7:0]         out_char,
    output logic               cell_nonzero,
    output logic [14:0]        head_position,
    output logic               status
);

    tme_pkg::cmd_t cmd;
    tme_pkg::sts_t sts;
    logic          in_accept;

    assign in_accept = in_valid && !in_stall;

    tme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    tme_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (opcode),
        .amount        (amount),
        .offset_first  (offset_first),
        .factor_first  (factor_first),
        .offset_second (offset_second),
        .factor_second (factor_second),
        .in_byte       (in_byte),
        .res_stall     (res_stall),
        .res_valid     (res_valid),
        .out_valid     (out_valid),
        .out_char      (out_char),
        .cell_nonzero  (cell_nonzero),
        .head_position (head_position),
        .status        (status)
    );

    // a result never shows up in the cycle right after its beat is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !$rose(res_valid))
        else $error("result beat appeared one cycle after accept");

    // a scan stopped at a tape end always sits on a nonzero cell
    a_status_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && status) |-> cell_nonzero)
        else $error("end-of-tape status with zero cell");

    // emitted byte agrees with the nonzero flag
    a_out_char_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid) |-> (cell_nonzero == (out_char != 8'h00)))
        else $error("out_char disagrees with cell_nonzero");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the tape machine execute unit
// Drives operation beats with random gaps, stalls the result channel at
// random, and checks every result beat against a tape and head model kept
// in the bench. Directed tests cover the extremes and corner cases; a long
// random phase then runs mixed programs around a drifting head.
// ============================================================================
module testbench;

    // spare opcodes that must behave as no-ops
    localparam tme_pkg::op_t OP_SPARE_LO = 4'd14;
    localparam tme_pkg::op_t OP_SPARE_HI = 4'd15;

    localparam int RANDOM_ITEMS = 1500;
    localparam int TAIL_CYCLES  = 20;
    // covers the tape clearing pass and a scan across the whole tape, x4
    localparam int QUIET_LIMIT  = 270000;

    typedef struct packed {
        tme_pkg::op_t       opcode;
        logic [14:0]        amount;
        logic signed [15:0] offset_first;
        logic [7:0]         factor_first;
        logic signed [15:0] offset_second;
        logic [7:0]         factor_second;
        logic [7:0]         in_byte;
    } op_beat_t;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_char;
        logic        cell_nonzero;
        logic [14:0] head_position;
        logic        status;
    } result_t;

    // DUT ports
    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [3:0]         opcode        = '0;
    logic [14:0]        amount        = '0;
    logic signed [15:0] offset_first  = '0;
    logic [7:0]         factor_first  = '0;
    logic signed [15:0] offset_second = '0;
    logic [7:0]         factor_second = '0;
    logic [7:0]         in_byte       = '0;
    logic               res_valid;
    logic               res_stall     = 1'b0;
    logic               out_valid;
    logic [7:0]         out_char;
    logic               cell_nonzero;
    logic [14:0]        head_position;
    logic               status;

    // tape model
    logic [7:0]  tape_img [tme_pkg::TAPE_CELLS];
    int unsigned head_img;

    result_t     expected_results [$];
    result_t     due_result;
    int unsigned rx_wait      = 0;
    bit          calm         = 1'b0;
    int          error_count  = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          end_stops    = 0;
    int          quiet_cycles = 0;

    tape_machine_execute_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .amount        (amount),
        .offset_first  (offset_first),
        .factor_first  (factor_first),
        .offset_second (offset_second),
        .factor_second (factor_second),
        .in_byte       (in_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_valid     (out_valid),
        .out_char      (out_char),
        .cell_nonzero  (cell_nonzero),
        .head_position (head_position),
        .status        (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // wait cycles before a beat; zero throughout a calm stretch
    function automatic int unsigned draw_wait();
        if (calm)
            return 0;
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 18);
            1:       return $urandom_range(0, 2);
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned clamp_cell(input int pos);
        if (pos > tme_pkg::TAPE_CELLS - 1)
            return tme_pkg::TAPE_CELLS - 1;
        if (pos < 0)
            return 0;
        return pos;
    endfunction

    // tape and head update for one operation, returns the expected beat
    function automatic result_t apply_op(input op_beat_t b);
        result_t     r;
        logic [7:0]  cur;
        int unsigned t1;
        int unsigned t2;
        r = '0;
        cur = tape_img[head_img];
        case (b.opcode)
            tme_pkg::OP_ADD:   tape_img[head_img] = cur + b.amount[7:0];
            tme_pkg::OP_SUB:   tape_img[head_img] = cur - b.amount[7:0];
            tme_pkg::OP_RIGHT: head_img = clamp_cell(int'(head_img) + int'(b.amount));
            tme_pkg::OP_LEFT:  head_img = clamp_cell(int'(head_img) - int'(b.amount));
            tme_pkg::OP_OUT:
            begin
                r.out_valid = 1'b1;
                r.out_char  = cur;
            end
            tme_pkg::OP_IN:    tape_img[head_img] = b.in_byte;
            tme_pkg::OP_CLEAR: tape_img[head_img] = 8'd0;
            tme_pkg::OP_SET:   tape_img[head_img] = b.amount[7:0];
            tme_pkg::OP_SCANR:
            begin
                while (tape_img[head_img] != 8'd0 && head_img != tme_pkg::TAPE_CELLS - 1)
                    head_img++;
                r.status = (tape_img[head_img] != 8'd0);
            end
            tme_pkg::OP_SCANL:
            begin
                while (tape_img[head_img] != 8'd0 && head_img != 0)
                    head_img--;
                r.status = (tape_img[head_img] != 8'd0);
            end
            tme_pkg::OP_MOVEADD, tme_pkg::OP_DIST:
            begin
                // additions first, then the source cell is cleared
                t1 = clamp_cell(int'(head_img) + int'(b.offset_first));
                tape_img[t1] = tape_img[t1] + 8'(cur * b.factor_first);
                if (b.opcode == tme_pkg::OP_DIST)
                begin
                    t2 = clamp_cell(int'(head_img) + int'(b.offset_second));
                    tape_img[t2] = tape_img[t2] + 8'(cur * b.factor_second);
                end
                tape_img[head_img] = 8'd0;
            end
            default: ;
        endcase
        r.cell_nonzero  = (tape_img[head_img] != 8'd0);
        r.head_position = head_img[14:0];
        return r;
    endfunction

    // one operation beat: random gap, then hold until accepted
    task automatic send_op(input tme_pkg::op_t op, input logic [14:0] amt = '0,
                           input logic signed [15:0] off1 = '0,
                           input logic [7:0] fac1 = '0,
                           input logic signed [15:0] off2 = '0,
                           input logic [7:0] fac2 = '0,
                           input logic [7:0] byte_in = '0);
        op_beat_t    beat;
        int unsigned gap;
        beat = '{op, amt, off1, fac1, off2, fac2, byte_in};
        gap = draw_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        amount        <= amt;
        offset_first  <= off1;
        factor_first  <= fac1;
        offset_second <= off2;
        factor_second <= fac2;
        in_byte       <= byte_in;
        do
            @(posedge clk);
        while (in_stall);
        expected_results = {expected_results, apply_op(beat)};
        items_sent++;
    endtask

    // sender goes quiet until every expected result has arrived
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no expected result pending");
                    error_count++;
                end
                else
                begin
                    due_result = expected_results.pop_front();
                    check_field("out_valid", due_result.out_valid, out_valid);
                    check_field("out_char", due_result.out_char, out_char);
                    check_field("cell_nonzero", due_result.cell_nonzero, cell_nonzero);
                    check_field("head_position", due_result.head_position, head_position);
                    check_field("status", due_result.status, status);
                    if (due_result.status)
                        end_stops++;
                end
                rx_wait = draw_wait();
                res_stall <= (rx_wait != 0);
            end
            else if (rx_wait != 0)
            begin
                rx_wait--;
                res_stall <= (rx_wait != 0);
            end
        end
    end

    // watchdog: cycles without any beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    // cell arithmetic, in/out, test/close and spare opcodes at head 0
    task automatic test_cell_ops();
        send_op(tme_pkg::OP_ADD, 15'h7FFF);
        send_op(tme_pkg::OP_OUT);
        send_op(tme_pkg::OP_SUB, 15'h00FF);
        send_op(tme_pkg::OP_SUB, 15'h0000);
        send_op(tme_pkg::OP_IN, '0, '0, '0, '0, '0, 8'hA5);
        send_op(tme_pkg::OP_SET, 15'h7F5A);
        send_op(tme_pkg::OP_TEST);
        send_op(tme_pkg::OP_CLEAR);
        send_op(tme_pkg::OP_CLOSE);
        send_op(OP_SPARE_LO, 15'h7FFF, 16'sh7FFF, 8'hFF, -16'sd32767, 8'hFF, 8'hFF);
        send_op(OP_SPARE_HI);
    endtask

    // head saturation at both ends and a scan stopping at the last cell
    task automatic test_head_clamp();
        send_op(tme_pkg::OP_RIGHT, 15'h7FFF);
        send_op(tme_pkg::OP_RIGHT, 15'd5);
        send_op(tme_pkg::OP_SET, 15'd7);
        send_op(tme_pkg::OP_SCANR);
        send_op(tme_pkg::OP_LEFT, 15'h7FFF);
        send_op(tme_pkg::OP_LEFT, 15'd1);
    endtask

    // scans across a short run and a scan stopping at the first cell
    task automatic test_scans();
        send_op(tme_pkg::OP_SET, 15'd1);
        send_op(tme_pkg::OP_SCANL);
        send_op(tme_pkg::OP_SCANR);
        send_op(tme_pkg::OP_SET, 15'd2);
        send_op(tme_pkg::OP_SCANL);
        send_op(tme_pkg::OP_RIGHT, 15'd1);
    endtask

    // move-add and distribute: clamped targets, target on head, shared target
    task automatic test_transfers();
        send_op(tme_pkg::OP_MOVEADD, '0, 16'sh7FFF, 8'hFF);
        send_op(tme_pkg::OP_SET, 15'd3);
        send_op(tme_pkg::OP_MOVEADD, '0, -16'sd32767, 8'd2);
        send_op(tme_pkg::OP_SET, 15'd5);
        send_op(tme_pkg::OP_MOVEADD, '0, 16'sd0, 8'd3);
        send_op(tme_pkg::OP_SET, 15'd9);
        send_op(tme_pkg::OP_DIST, '0, 16'sd1, 8'hFF, 16'sd1, 8'd1);
        send_op(tme_pkg::OP_SET, 15'd4);
        send_op(tme_pkg::OP_DIST, '0, 16'sd0, 8'd7, -16'sd1, 8'd0);
    endtask

    function automatic tme_pkg::op_t pick_opcode();
        int p;
        p = $urandom_range(0, 99);
        if (p < 15) return tme_pkg::OP_ADD;
        if (p < 25) return tme_pkg::OP_SUB;
        if (p < 35) return tme_pkg::OP_RIGHT;
        if (p < 45) return tme_pkg::OP_LEFT;
        if (p < 51) return tme_pkg::OP_OUT;
        if (p < 59) return tme_pkg::OP_IN;
        if (p < 64) return tme_pkg::OP_TEST;
        if (p < 67) return tme_pkg::OP_CLOSE;
        if (p < 71) return tme_pkg::OP_CLEAR;
        if (p < 79) return tme_pkg::OP_SET;
        if (p < 84) return tme_pkg::OP_SCANR;
        if (p < 89) return tme_pkg::OP_SCANL;
        if (p < 94) return tme_pkg::OP_MOVEADD;
        if (p < 99) return tme_pkg::OP_DIST;
        return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    endfunction

    // mostly near offsets, sometimes anywhere in the legal range
    function automatic logic signed [15:0] pick_offset();
        if ($urandom_range(0, 9) == 0)
            return 16'(int'($urandom_range(0, 65534)) - 32767);
        return 16'(int'($urandom_range(0, 12)) - 6);
    endfunction

    // mixed programs around a drifting head, with calm stretches
    task automatic test_random_programs();
        tme_pkg::op_t op;
        logic [14:0]  amt;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                wait_for_results();
            op = pick_opcode();
            if ((op == tme_pkg::OP_RIGHT || op == tme_pkg::OP_LEFT)
                && $urandom_range(0, 19) != 0)
                amt = 15'($urandom_range(0, 4));
            else
                amt = 15'($urandom_range(0, 32767));
            send_op(op, amt, pick_offset(), 8'($urandom_range(0, 255)),
                    pick_offset(), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < tme_pkg::TAPE_CELLS; i++)
            tape_img[i] = 8'd0;
        head_img = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_cell_ops();
        test_head_clamp();
        test_scans();
        test_transfers();
        test_random_programs();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d operation beats and %0d result beats, all opcodes",
                 items_sent, results_seen);
        $display("including %0d scans stopped at a tape end", end_stops);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
